// ===== design/ipmd_pkg.sv =====
// Package for the incremental PI motor drive unit: item structs, register
// map, widths and reset values. No dependencies; used by every design file.

package ipmd_pkg;

    // Register file layout and reset values.
    localparam int unsigned ADDR_W    = 4;
    localparam int unsigned DATA_W    = 32;
    localparam int unsigned GAIN_W    = 12;
    localparam int unsigned LIMIT_W   = 15;

    localparam logic [GAIN_W-1:0]  PROP_GAIN_RESET   = 12'd120;
    localparam logic [GAIN_W-1:0]  INTEG_GAIN_RESET  = 12'd30;
    localparam logic [LIMIT_W-1:0] DRIVE_LIMIT_RESET = 15'd7200;

    // Datapath widths.
    localparam int unsigned IDX_W   = 2;
    localparam int unsigned SPEED_W = 16;
    localparam int unsigned DRIVE_W = 16;
    localparam int unsigned DUTY_W  = 15;
    localparam int unsigned ERR_W   = 17;
    localparam int unsigned DERR_W  = 18;
    localparam int unsigned PTERM_W = GAIN_W + 1 + DERR_W;
    localparam int unsigned ITERM_W = GAIN_W + 1 + ERR_W;
    localparam int unsigned ACC_W   = 33;

    typedef enum logic [1:0] {
        REG_PROP_GAIN   = 2'd0,
        REG_INTEG_GAIN  = 2'd1,
        REG_DRIVE_LIMIT = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic [IDX_W-1:0]          motor_index;
        logic signed [SPEED_W-1:0] encoder_delta;
        logic signed [SPEED_W-1:0] target_speed;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0]          motor_out_index;
        logic signed [DRIVE_W-1:0] drive_signed;
        logic [DUTY_W-1:0]         duty_forward;
        logic [DUTY_W-1:0]         duty_reverse;
    } out_item_t;

    typedef struct packed {
        logic [GAIN_W-1:0]  prop_gain;
        logic [GAIN_W-1:0]  integ_gain;
        logic [LIMIT_W-1:0] drive_limit;
    } ctrl_cfg_t;

endpackage

// ===== design/ipmd_update.sv =====
// Control law for one tick: error, PI increment, clamp, zero-target reset and duty split.
// Purely combinational. Depends on ipmd_pkg.

module ipmd_update
    import ipmd_pkg::*;
(
    input  in_item_t                   item,
    input  logic                       in_range,
    input  ctrl_cfg_t                  cfg,
    input  logic signed [DRIVE_W-1:0]  accum,
    input  logic signed [ERR_W-1:0]    prev_err,
    output logic signed [DRIVE_W-1:0]  accum_next,
    output logic signed [ERR_W-1:0]    err_next,
    output out_item_t                  result
);

    logic signed [ERR_W-1:0]   err;
    logic signed [DERR_W-1:0]  derr;
    logic signed [PTERM_W-1:0] pterm;
    logic signed [ITERM_W-1:0] iterm;
    logic signed [ACC_W-1:0]   sum;
    logic signed [ACC_W-1:0]   lim;
    logic signed [ACC_W-1:0]   clamped;
    logic signed [DRIVE_W-1:0] drive;
    logic signed [DRIVE_W-1:0] drive_neg;

    always_comb
    begin
        err   = ERR_W'(item.target_speed) - ERR_W'(item.encoder_delta);
        derr  = DERR_W'(err) - DERR_W'(prev_err);
        pterm = PTERM_W'($signed({1'b0, cfg.prop_gain}) * derr);
        iterm = ITERM_W'($signed({1'b0, cfg.integ_gain}) * err);
        // The sum is wide enough that it never wraps before the clamp.
        sum   = ACC_W'(accum) + ACC_W'(pterm) + ACC_W'(iterm);
        lim   = $signed(ACC_W'({1'b0, cfg.drive_limit}));

        if (sum > lim)
        begin
            clamped = lim;
        end
        else if (sum < -lim)
        begin
            clamped = -lim;
        end
        else
        begin
            clamped = sum;
        end

        if (item.target_speed == '0)
        begin
            accum_next = '0;
            err_next   = '0;
        end
        else
        begin
            accum_next = clamped[DRIVE_W-1:0];
            err_next   = err;
        end

        drive     = in_range ? accum_next : '0;
        drive_neg = -drive;

        result.motor_out_index = item.motor_index;
        result.drive_signed    = drive;
        result.duty_forward    = (drive > 0) ? drive[DUTY_W-1:0] : '0;
        result.duty_reverse    = (drive < 0) ? drive_neg[DUTY_W-1:0] : '0;
    end

endmodule

// ===== design/incremental_pi_motor_drive_unit.sv =====
// Top level of the incremental PI motor drive unit: APB register file,
// input and result registers, per-motor state. Uses ipmd_pkg, ipmd_update.
//
//  Channel  Direction  Handshake             Payload
//  in       into unit  in_valid / in_ready   in_item  (in_item_t)
//  out      from unit  out_valid / out_ready out_item (out_item_t)
//  config   into unit  psel/penable/pready   paddr, pwdata, prdata
//
// One item per cycle sustained while the output is not stalled; an accepted
// item waits in the input register, and the update and the state write happen
// as it moves from the input register into the result register.
// A stalled output holds its result; the input register still takes one
// more item, then in_ready drops until the result is taken.
// Reset sets the gains and the drive limit to their defaults and clears all motor state.

module incremental_pi_motor_drive_unit
    import ipmd_pkg::*;
#(
    parameter int MOTOR_COUNT = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  in_item_t          in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output out_item_t         out_item,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    ctrl_cfg_t  cfg_reg;
    reg_index_t reg_sel;
    logic       cfg_write;

    logic       s1_valid_reg;
    in_item_t   s1_item_reg;
    logic       out_valid_reg;
    out_item_t  out_item_reg;
    logic       advance;
    logic       in_range;

    logic signed [DRIVE_W-1:0] accum_reg [MOTOR_COUNT];
    logic signed [ERR_W-1:0]   err_reg   [MOTOR_COUNT];
    logic signed [DRIVE_W-1:0] accum_sel;
    logic signed [ERR_W-1:0]   err_sel;
    logic signed [DRIVE_W-1:0] accum_next;
    logic signed [ERR_W-1:0]   err_next;
    out_item_t                 result;

    // Register file.
    assign pready    = 1'b1;
    assign reg_sel   = reg_index_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        case (reg_sel)
            REG_PROP_GAIN:   prdata = DATA_W'(cfg_reg.prop_gain);
            REG_INTEG_GAIN:  prdata = DATA_W'(cfg_reg.integ_gain);
            REG_DRIVE_LIMIT: prdata = DATA_W'(cfg_reg.drive_limit);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prop_gain   <= PROP_GAIN_RESET;
            cfg_reg.integ_gain  <= INTEG_GAIN_RESET;
            cfg_reg.drive_limit <= DRIVE_LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_sel)
                REG_PROP_GAIN:   cfg_reg.prop_gain   <= pwdata[GAIN_W-1:0];
                REG_INTEG_GAIN:  cfg_reg.integ_gain  <= pwdata[GAIN_W-1:0];
                REG_DRIVE_LIMIT: cfg_reg.drive_limit <= pwdata[LIMIT_W-1:0];
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Handshake: the item in the input register moves on whenever the
    // result register is empty or its result is being taken.
    assign advance   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_item_reg <= in_item;
        end
        if (advance)
        begin
            out_item_reg <= result;
        end
    end

    // State of the addressed motor. Earlier items have already written
    // their state back by the time this one is in the input register.
    assign in_range = 32'(s1_item_reg.motor_index) < MOTOR_COUNT;

    always_comb
    begin
        accum_sel = '0;
        err_sel   = '0;
        for (int i = 0; i < MOTOR_COUNT; i++)
        begin
            if (32'(s1_item_reg.motor_index) == i)
            begin
                accum_sel = accum_reg[i];
                err_sel   = err_reg[i];
            end
        end
    end

    ipmd_update u_update (
        .item       (s1_item_reg),
        .in_range   (in_range),
        .cfg        (cfg_reg),
        .accum      (accum_sel),
        .prev_err   (err_sel),
        .accum_next (accum_next),
        .err_next   (err_next),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MOTOR_COUNT; i++)
            begin
                accum_reg[i] <= '0;
                err_reg[i]   <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < MOTOR_COUNT; i++)
            begin
                if (advance && in_range && (32'(s1_item_reg.motor_index) == i))
                begin
                    accum_reg[i] <= accum_next;
                    err_reg[i]   <= err_next;
                end
            end
        end
    end

    // A result never drives both channels at once.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_item_reg.duty_forward == '0 ||
                           out_item_reg.duty_reverse == '0))
        else $error("both duty channels active");

    // A delivered drive stays within the configured bound.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |->
            (out_item_reg.drive_signed <= $signed({1'b0, cfg_reg.drive_limit}) &&
             out_item_reg.drive_signed >= -$signed({1'b0, cfg_reg.drive_limit})))
        else $error("drive outside limit");

    // An item held in the input register is not dropped while output stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !advance) |=> s1_valid_reg)
        else $error("input register lost an item");

endmodule

// ===== test/incremental_pi_motor_drive_unit_test.sv =====
// Self-checking testbench for incremental_pi_motor_drive_unit: a directed table and then
// random motor ticks under several gain and limit settings, checked against a local PI model.
// Depends on ipmd_pkg and the unit's RTL only.

module incremental_pi_motor_drive_unit_test;
    import ipmd_pkg::*;

    localparam int MOTOR_COUNT      = 4;
    localparam int PHASE_COUNT      = 10;
    localparam int TICKS_PER_PHASE  = 120;
    localparam int DIRECTED_ROWS    = 17;
    localparam int CYCLE_LIMIT      = 400000;
    localparam int SETTLE_CYCLES    = 8;
    localparam int MAX_REPORTS      = 10;
    localparam logic [1:0] UNMAPPED_REG = 2'd3;
    // Marks a gain or limit setting that is drawn at random for that phase.
    localparam int PICK_RANDOM      = -1;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    in_item_t          in_item = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    out_item_t         out_item;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    // Local copy of the register file and of each motor's controller state.
    logic [GAIN_W-1:0]  prop_gain_q = PROP_GAIN_RESET;
    logic [GAIN_W-1:0]  integ_gain_q = INTEG_GAIN_RESET;
    logic [LIMIT_W-1:0] drive_limit_q = DRIVE_LIMIT_RESET;
    longint             motor_drive [MOTOR_COUNT];
    longint             motor_last_err [MOTOR_COUNT];

    out_item_t drive_expect_q [$];
    int        fail_count = 0;
    int        cycle_count = 0;
    int        burst_left = 0;
    bit        source_steady = 1'b0;
    bit        sink_steady = 1'b0;
    int        ready_hold = 0;
    bit        ready_next;

    int corner_values [5] = '{-32768, -1, 0, 1, 32767};

    // motor, encoder delta, target, typed, drive, forward duty, reverse duty
    int directed_tab [DIRECTED_ROWS][7] = '{
        '{0,      0,      0, 1,     0,    0,    0},
        '{0, -32768,  32767, 1,  7200, 7200,    0},
        '{1,  32767, -32768, 1, -7200,    0, 7200},
        '{2,      1,      1, 1,     0,    0,    0},
        '{3,      3,      5, 1,   300,  300,    0},
        '{3,      5,      5, 0,     0,    0,    0},
        '{3,      8,      5, 0,     0,    0,    0},
        '{0,  32767,  32767, 0,     0,    0,    0},
        '{0, -32768, -32768, 0,     0,    0,    0},
        '{1,      0,      0, 1,     0,    0,    0},
        '{1, -32768,      1, 0,     0,    0,    0},
        '{2,  32767,     -1, 0,     0,    0,    0},
        '{0,      0,      0, 1,     0,    0,    0},
        '{2,      0, -32768, 0,     0,    0,    0},
        '{3,     -1,  32767, 0,     0,    0,    0},
        '{1,  21845,  10922, 0,     0,    0,    0},
        '{2, -21846, -10923, 0,     0,    0,    0}
    };

    // prop gain, integ gain, drive limit; phase 0 keeps the reset values.
    int phase_cfg [PHASE_COUNT][3] = '{
        '{ 120,   30,  7200},
        '{   0,    0,     0},
        '{4095, 4095, 32767},
        '{   1,    1, 32767},
        '{4095,    0,   100},
        '{   0, 4095,     1},
        '{ 120,   30,  7200},
        '{PICK_RANDOM, PICK_RANDOM, PICK_RANDOM},
        '{PICK_RANDOM, PICK_RANDOM, PICK_RANDOM},
        '{PICK_RANDOM, PICK_RANDOM, PICK_RANDOM}
    };

    incremental_pi_motor_drive_unit #(
        .MOTOR_COUNT(MOTOR_COUNT)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void flag_error(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
        begin
            $display("%s", msg);
        end
    endfunction

    // One PI update of the addressed motor; returns the result item it produces.
    function automatic out_item_t advance_motor(input in_item_t tick);
        out_item_t   res;
        longint      err;
        longint      sum;
        longint      lim;
        longint      drive;
        longint      magnitude;
        int unsigned m;
        m = 32'(tick.motor_index);
        if (tick.target_speed == 0)
        begin
            motor_drive[m] = 0;
            motor_last_err[m] = 0;
        end
        else
        begin
            err = longint'($signed(tick.target_speed)) - longint'($signed(tick.encoder_delta));
            lim = longint'(drive_limit_q);
            sum = motor_drive[m] + longint'(prop_gain_q) * (err - motor_last_err[m])
                + longint'(integ_gain_q) * err;
            if (sum > lim)
            begin
                sum = lim;
            end
            if (sum < -lim)
            begin
                sum = -lim;
            end
            motor_drive[m] = sum;
            motor_last_err[m] = err;
        end
        drive = motor_drive[m];
        magnitude = -drive;
        res.motor_out_index = tick.motor_index;
        res.drive_signed = drive[DRIVE_W-1:0];
        res.duty_forward = (drive > 0) ? drive[DUTY_W-1:0] : '0;
        res.duty_reverse = (drive < 0) ? magnitude[DUTY_W-1:0] : '0;
        return res;
    endfunction

    // Mostly ticks that track a moderate target, plus zero targets, corners and noise.
    function automatic in_item_t random_tick();
        in_item_t tick;
        int       pick;
        int       target;
        int       delta;
        pick = $urandom_range(0, 99);
        target = int'($urandom_range(0, 65535)) - 32768;
        delta = int'($urandom_range(0, 65535)) - 32768;
        if (pick < 8)
        begin
            target = 0;
        end
        else if (pick < 14)
        begin
            target = corner_values[$urandom_range(0, 4)];
            delta = corner_values[$urandom_range(0, 4)];
        end
        else if (pick >= 40)
        begin
            target = int'($urandom_range(0, 600)) - 300;
            delta = target + int'($urandom_range(0, 24)) - 12;
        end
        tick.motor_index = IDX_W'($urandom_range(0, MOTOR_COUNT - 1));
        tick.target_speed = 16'(target);
        tick.encoder_delta = 16'(delta);
        return tick;
    endfunction

    // Upper bits beyond the register width carry random junk half of the time.
    function automatic logic [DATA_W-1:0] with_noise(input int unsigned setting,
                                                     input int unsigned width);
        logic [DATA_W-1:0] noise;
        noise = $urandom();
        if ($urandom_range(0, 1) == 0)
        begin
            noise = '0;
        end
        return (noise << width) | DATA_W'(setting);
    endfunction

    task automatic write_reg(input logic [1:0] reg_sel, input logic [DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_sel, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (reg_sel)
            REG_PROP_GAIN:   prop_gain_q = value[GAIN_W-1:0];
            REG_INTEG_GAIN:  integ_gain_q = value[GAIN_W-1:0];
            REG_DRIVE_LIMIT: drive_limit_q = value[LIMIT_W-1:0];
            default:         ;
        endcase
    endtask

    task automatic send_tick(input in_item_t tick, input bit typed, input out_item_t want);
        out_item_t predicted;
        int        gap;
        if (burst_left == 0)
        begin
            gap = source_steady ? 0 : $urandom_range(0, 12);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        in_item <= tick;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        burst_left--;
        predicted = advance_motor(tick);
        drive_expect_q.push_back(typed ? want : predicted);
    endtask

    // Stops sending and waits until every outstanding result has been taken.
    task automatic drain_all();
        in_valid <= 1'b0;
        burst_left = 0;
        while (drive_expect_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            ready_hold = 0;
        end
        else if (sink_steady)
        begin
            out_ready <= 1'b1;
        end
        else if (ready_hold != 0)
        begin
            ready_hold--;
        end
        else
        begin
            ready_next = ($urandom_range(0, 2) != 0);
            out_ready <= ready_next;
            ready_hold = ready_next ? $urandom_range(0, 14) : $urandom_range(0, 7);
        end
    end

    always @(posedge clk)
    begin : check_results
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (drive_expect_q.size() == 0)
            begin
                flag_error($sformatf("Unexpected result: motor %0d drive %0d",
                                     out_item.motor_out_index, out_item.drive_signed));
            end
            else
            begin
                want = drive_expect_q.pop_front();
                if (out_item.motor_out_index !== want.motor_out_index
                    || out_item.drive_signed !== want.drive_signed
                    || out_item.duty_forward !== want.duty_forward
                    || out_item.duty_reverse !== want.duty_reverse)
                begin
                    flag_error($sformatf(
                        "Mismatch: expected motor %0d drive %0d fwd %0d rev %0d, got %0d %0d %0d %0d",
                        want.motor_out_index, want.drive_signed, want.duty_forward,
                        want.duty_reverse, out_item.motor_out_index, out_item.drive_signed,
                        out_item.duty_forward, out_item.duty_reverse));
                end
            end
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    initial
    begin : stimulus
        in_item_t  tick;
        out_item_t want;
        int        kp;
        int        ki;
        int        lim;
        for (int m = 0; m < MOTOR_COUNT; m++)
        begin
            motor_drive[m] = 0;
            motor_last_err[m] = 0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIRECTED_ROWS; r++)
        begin
            tick.motor_index = IDX_W'(directed_tab[r][0]);
            tick.encoder_delta = 16'(directed_tab[r][1]);
            tick.target_speed = 16'(directed_tab[r][2]);
            want.motor_out_index = tick.motor_index;
            want.drive_signed = 16'(directed_tab[r][4]);
            want.duty_forward = 15'(directed_tab[r][5]);
            want.duty_reverse = 15'(directed_tab[r][6]);
            send_tick(tick, directed_tab[r][3] != 0, want);
        end

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            if (p != 0)
            begin
                drain_all();
                kp = (phase_cfg[p][0] == PICK_RANDOM) ? $urandom_range(0, 300) : phase_cfg[p][0];
                ki = (phase_cfg[p][1] == PICK_RANDOM) ? $urandom_range(0, 100) : phase_cfg[p][1];
                lim = (phase_cfg[p][2] == PICK_RANDOM)
                    ? $urandom_range(0, 32767) : phase_cfg[p][2];
                write_reg(REG_PROP_GAIN, with_noise(kp, GAIN_W));
                write_reg(REG_INTEG_GAIN, with_noise(ki, GAIN_W));
                write_reg(REG_DRIVE_LIMIT, with_noise(lim, LIMIT_W));
                if (p % 3 == 1)
                begin
                    write_reg(UNMAPPED_REG, $urandom());
                end
            end
            // Some phases run without idling on one or both sides.
            source_steady = (p % 4 == 3) || (p % 4 == 1);
            sink_steady = (p % 4 == 3);
            for (int n = 0; n < TICKS_PER_PHASE; n++)
            begin
                if ($urandom_range(0, 150) == 0)
                begin
                    drain_all();
                end
                send_tick(random_tick(), 1'b0, want);
            end
        end

        drain_all();
        if (fail_count == 0 && drive_expect_q.size() == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
